// File: rtl/bgd_pkg.sv
`default_nettype none

package bgd_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int TALLY_BITS = 8;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MULTI_GAP  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EN_LONG    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_EN_MULTI   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERT_PIN = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_PRESS   = 2'd1,
    EDGE_RELEASE = 2'd2,
    EDGE_LONG    = 2'd3
  } edge_t;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_TRIPLE = 2'd3
  } gesture_t;

  typedef struct packed {
    logic [TIMER_BITS-1:0] debounce_ticks;
    logic [TIMER_BITS-1:0] long_press_ticks;
    logic [TIMER_BITS-1:0] multi_click_ticks;
    logic                  long_press_on;
    logic                  multi_click_on;
    logic                  invert_pin;
  } bgd_cfg_t;

  typedef struct packed {
    logic                  last_raw;
    logic [TIMER_BITS-1:0] stable_timer;
    logic                  debounced_level;
    phase_t                phase;
    logic [TIMER_BITS-1:0] press_timer;
    logic                  long_fired;
    logic [TALLY_BITS-1:0] click_tally;
    logic [TIMER_BITS-1:0] gap_timer;
    logic                  click_pending;
  } bgd_state_t;

  typedef struct packed {
    edge_t                 edge_event;
    logic [TALLY_BITS-1:0] edge_count;
    gesture_t              gesture_event;
    logic [1:0]            gesture_clicks;
    logic                  pressed;
    logic [TALLY_BITS-1:0] clicks_so_far;
  } bgd_result_t;

endpackage

`default_nettype wire

// File: rtl/bgd_step.sv
`default_nettype none

module bgd_step (
  input  wire bgd_pkg::bgd_cfg_t    cfg,
  input  wire bgd_pkg::bgd_state_t  cur,
  input  wire logic                 raw_level,
  output bgd_pkg::bgd_state_t       nxt,
  output bgd_pkg::bgd_result_t      res
);
  import bgd_pkg::*;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
    return (t == TIMER_MAX) ? TIMER_MAX : t + TIMER_BITS'(1);
  endfunction

  logic                  lvl;
  logic                  short_press;
  logic [TIMER_BITS-1:0] long_lim;
  logic [1:0]            gclicks;

  assign lvl      = raw_level ^ cfg.invert_pin;
  assign long_lim = (cfg.long_press_ticks == '0) ? TIMER_BITS'(1) : cfg.long_press_ticks;

  always_comb begin
    nxt         = cur;
    res         = '0;
    short_press = 1'b1;
    gclicks     = '0;

    if (lvl != cur.last_raw) begin
      nxt.last_raw     = lvl;
      nxt.stable_timer = '0;
    end else begin
      nxt.stable_timer = sat_inc(cur.stable_timer);
    end
    nxt.press_timer = sat_inc(cur.press_timer);
    nxt.gap_timer   = sat_inc(cur.gap_timer);

    if (cur.click_pending) begin
      // deferred lone click: this tick reports it and decides nothing else
      nxt.click_pending  = 1'b0;
      res.gesture_event  = GEST_SINGLE;
      res.gesture_clicks = 2'd1;
    end else begin
      if (nxt.stable_timer >= cfg.debounce_ticks && nxt.last_raw != cur.debounced_level) begin
        nxt.debounced_level = nxt.last_raw;
        if (nxt.last_raw) begin
          nxt.phase       = PH_PRESSED;
          nxt.press_timer = '0;
          nxt.long_fired  = 1'b0;
          res.edge_event  = EDGE_PRESS;
        end else begin
          nxt.phase = PH_RELEASED;
          if (cfg.long_press_on || cfg.multi_click_on) begin
            short_press = nxt.press_timer < cfg.long_press_ticks;
          end
          if (short_press && !nxt.long_fired) begin
            if (!cfg.multi_click_on) begin
              nxt.click_pending = 1'b1;
              nxt.click_tally   = '0;
            end else begin
              if (nxt.click_tally != TALLY_MAX) begin
                nxt.click_tally = nxt.click_tally + TALLY_BITS'(1);
              end
              nxt.gap_timer = '0;
            end
          end
          res.edge_event = EDGE_RELEASE;
        end
        res.edge_count = nxt.click_tally;
      end

      if (nxt.phase == PH_RELEASED && !nxt.debounced_level) begin
        nxt.phase = PH_IDLE;
      end

      if (nxt.phase == PH_PRESSED && !nxt.long_fired && cfg.long_press_on &&
          nxt.press_timer >= long_lim) begin
        nxt.long_fired  = 1'b1;
        nxt.phase       = PH_LONG;
        nxt.click_tally = '0;
        res.edge_event  = EDGE_LONG;
        res.edge_count  = '0;
      end

      // close the sequence after the quiet gap; four or more clicks report as triple
      if (cfg.multi_click_on && nxt.click_tally != '0 && nxt.phase == PH_IDLE &&
          nxt.gap_timer >= cfg.multi_click_ticks) begin
        gclicks            = (nxt.click_tally > TALLY_BITS'(3)) ? 2'd3 : nxt.click_tally[1:0];
        res.gesture_clicks = gclicks;
        res.gesture_event  = gesture_t'(gclicks);
        nxt.click_tally    = '0;
      end
    end

    res.pressed       = nxt.debounced_level;
    res.clicks_so_far = nxt.click_tally;
  end

endmodule

`default_nettype wire

// File: rtl/button_gesture_detector_core.sv
`default_nettype none

// Button gesture detector. Each input word is one time tick carrying the raw
// pin level; each accepted tick yields exactly one result word with press,
// release and long-press edges, click / double / triple gestures, the
// debounced level and the open click count. A tick is taken every clock
// cycle unless an untaken result holds it back: the whole per-tick update
// is one combinational pass from the held state into the state registers and
// the output register, so the result of a tick is offered in the cycle after
// it is accepted and a new tick may enter in the same cycle the previous result
// is taken. Registers are written through cfg_we / cfg_index / cfg_data and
// should change only while no tick is in flight; unknown indexes are ignored.
module button_gesture_detector_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              raw_level,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             edge_event,
  output logic [bgd_pkg::TALLY_BITS-1:0]         edge_count,
  output logic [1:0]                             gesture_event,
  output logic [1:0]                             gesture_clicks,
  output logic                                   pressed,
  output logic [bgd_pkg::TALLY_BITS-1:0]         clicks_so_far,
  input  wire logic                              cfg_we,
  input  wire logic [bgd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [bgd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import bgd_pkg::*;

  bgd_cfg_t    cfg;
  bgd_state_t  state;
  bgd_state_t  state_next;
  bgd_result_t result;
  bgd_result_t result_next;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= TIMER_BITS'(50);
      cfg.long_press_ticks  <= TIMER_BITS'(1000);
      cfg.multi_click_ticks <= TIMER_BITS'(300);
      cfg.long_press_on     <= 1'b1;
      cfg.multi_click_on    <= 1'b1;
      cfg.invert_pin        <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   cfg.debounce_ticks    <= cfg_data[TIMER_BITS-1:0];
        REG_LONG_PRESS: cfg.long_press_ticks  <= cfg_data[TIMER_BITS-1:0];
        REG_MULTI_GAP:  cfg.multi_click_ticks <= cfg_data[TIMER_BITS-1:0];
        REG_EN_LONG:    cfg.long_press_on     <= cfg_data[0];
        REG_EN_MULTI:   cfg.multi_click_on    <= cfg_data[0];
        REG_INVERT_PIN: cfg.invert_pin        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bgd_step u_step (
    .cfg       (cfg),
    .cur       (state),
    .raw_level (raw_level),
    .nxt       (state_next),
    .res       (result_next)
  );

  // all-zero state is released and idle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // output word: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign edge_event     = result.edge_event;
  assign edge_count     = result.edge_count;
  assign gesture_event  = result.gesture_event;
  assign gesture_clicks = result.gesture_clicks;
  assign pressed        = result.pressed;
  assign clicks_so_far  = result.clicks_so_far;

  a_long_not_pressed: assert property (@(posedge clk) disable iff (rst)
    !(state.phase == PH_PRESSED && state.long_fired))
    else $error("long press fired while phase still pressed");

  a_pending_clears_tally: assert property (@(posedge clk) disable iff (rst)
    state.click_pending |-> (state.click_tally == '0))
    else $error("pending lone click with open click tally");

  a_gesture_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gesture_clicks == gesture_event))
    else $error("gesture code and click count disagree");

  a_long_no_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && edge_event == EDGE_LONG) |-> (edge_count == '0 && clicks_so_far == '0))
    else $error("long press word carries a click count");

endmodule

`default_nettype wire
